// ----- hdl/esc_pkg.sv -----
// ----------------------------------------------------------------------------
// esc_pkg
// Shared constants, types and month table for the epoch-to-date converter.
// ----------------------------------------------------------------------------
package esc_pkg;

  localparam int unsigned SECS_PER_DAY  = 86400;
  localparam int unsigned SECS_PER_HOUR = 3600;
  localparam int unsigned SECS_PER_MIN  = 60;
  localparam int unsigned DAYS_PER_QUAD = 365 + 365 + 366 + 365;
  localparam int unsigned BASE_YEAR     = 70;
  localparam int unsigned SKIPPED_LEAP  = 200;
  // day count of 2100-03-01 from 1970-01-01 (130 years, 32 leap days, + Jan/Feb)
  localparam int unsigned MAR1_2100     = 130 * 365 + 32 + 59;

  localparam int unsigned DIV_REM_W = 17;
  localparam int unsigned DIV_SH_W  = 16;
  localparam int unsigned DIV_CNT_W = 5;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DAY,
    S_HOUR,
    S_MIN,
    S_YEAR,
    S_PICK,
    S_MONTH,
    S_OUT
  } state_t;

  typedef struct packed {
    logic                 start;
    logic [DIV_REM_W-1:0] rem_init;
    logic [DIV_SH_W-1:0]  low_init;
    logic [DIV_REM_W-1:0] divisor;
    logic [DIV_CNT_W-1:0] nbits;
  } div_req_t;

  typedef struct packed {
    logic                 step;
    logic                 qbit;
    logic                 done;
    logic [DIV_SH_W-1:0]  quo;
    logic [DIV_REM_W-1:0] rem;
  } div_rsp_t;

  function automatic logic [4:0] month_len(input logic [3:0] mon, input logic leap);
    logic [4:0] len;
    case (mon)
      4'd0:    len = 5'd31;
      4'd1:    len = leap ? 5'd29 : 5'd28;
      4'd2:    len = 5'd31;
      4'd3:    len = 5'd30;
      4'd4:    len = 5'd31;
      4'd5:    len = 5'd30;
      4'd6:    len = 5'd31;
      4'd7:    len = 5'd31;
      4'd8:    len = 5'd30;
      4'd9:    len = 5'd31;
      4'd10:   len = 5'd30;
      4'd11:   len = 5'd31;
      default: len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

// ----- hdl/esc_serial_div.sv -----
// ----------------------------------------------------------------------------
// esc_serial_div
// Restoring divider, one quotient bit per cycle, quotient shifted in MSB first.
// ----------------------------------------------------------------------------
module esc_serial_div import esc_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic [DIV_REM_W-1:0] rem_r, rem_nxt;
  logic [DIV_SH_W-1:0]  sh_r, sh_nxt;
  logic [DIV_REM_W-1:0] dvs_r, dvs_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                 run_r, run_nxt;
  logic                 done_r, done_nxt;

  logic [DIV_REM_W:0]   shifted;
  logic [DIV_REM_W:0]   trial;
  logic                 ge;

  // rem_init must stay below the divisor, so the shifted remainder fits
  assign shifted = {rem_r, sh_r[DIV_SH_W-1]};
  assign trial   = shifted - {1'b0, dvs_r};
  assign ge      = ~trial[DIV_REM_W];

  always_comb begin
    rem_nxt  = rem_r;
    sh_nxt   = sh_r;
    dvs_nxt  = dvs_r;
    cnt_nxt  = cnt_r;
    run_nxt  = run_r;
    done_nxt = 1'b0;
    if (req.start) begin
      rem_nxt = req.rem_init;
      sh_nxt  = req.low_init;
      dvs_nxt = req.divisor;
      cnt_nxt = req.nbits;
      run_nxt = 1'b1;
    end else if (run_r) begin
      rem_nxt = ge ? trial[DIV_REM_W-1:0] : shifted[DIV_REM_W-1:0];
      sh_nxt  = {sh_r[DIV_SH_W-2:0], ge};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == DIV_CNT_W'(1)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    sh_r  <= sh_nxt;
    dvs_r <= dvs_nxt;
  end

  assign rsp.step = run_r;
  assign rsp.qbit = ge;
  assign rsp.done = done_r;
  assign rsp.quo  = sh_r;
  assign rsp.rem  = rem_r;

endmodule

// ----- hdl/epoch_seconds_to_calendar_date_core.sv -----
// ----------------------------------------------------------------------------
// epoch_seconds_to_calendar_date_core
// Local calendar fields from a 32-bit epoch second count plus an hour offset.
// ----------------------------------------------------------------------------
// Sequence: after the accepting edge the serial divider works out days, hours,
//   minutes and years in turn, then S_PICK and a month walk in S_MONTH lead to S_OUT.
// Throughput: one word at a time; start is taken the cycle after out_valid.
//   The restoring divider (one bit per cycle) is shared by all four divisions.
// Reset: synchronous, active low; idles with the offset set to +9 hours.
// Results cannot be stalled: out_valid lasts exactly one cycle.
module epoch_seconds_to_calendar_date_core import esc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] in_epoch_seconds,
  input  logic        cfg_we,
  input  logic [4:0]  cfg_tz_offset_hours,
  output logic        out_valid,
  output logic [7:0]  out_year_since_1900,
  output logic [3:0]  out_month_index,
  output logic [4:0]  out_day_of_month,
  output logic [4:0]  out_hour_of_day,
  output logic [5:0]  out_minute_of_hour,
  output logic [5:0]  out_second_of_minute,
  output logic [2:0]  out_weekday,
  output logic [4:0]  out_days_in_month
);

  state_t state_r, state_nxt;

  logic [4:0]  tz_r;
  logic [15:0] days_r, days_nxt;
  logic [2:0]  wd_r, wd_nxt;
  logic [4:0]  hour_r, hour_nxt;
  logic [5:0]  min_r, min_nxt;
  logic [5:0]  sec_r, sec_nxt;
  logic [7:0]  year_r, year_nxt;
  logic [8:0]  dy_r, dy_nxt;
  logic [3:0]  mon_r, mon_nxt;
  logic        leap_r, leap_nxt;

  div_req_t div_req;
  div_rsp_t div_rsp;

  logic signed [17:0] tz_ext;
  logic signed [17:0] adj;
  logic [31:0]        local_t;
  logic [15:0]        days_adj;
  logic [3:0]         wd_dbl;
  logic [4:0]         cur_len;
  logic [3:0]         wd_sum;

  esc_serial_div u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (div_req),
    .rsp  (div_rsp)
  );

  assign tz_ext  = {{13{tz_r[4]}}, tz_r};
  assign adj     = tz_ext * 18'sd3600;
  assign local_t = in_epoch_seconds + {{14{adj[17]}}, adj};

  // pretend 2100 has a Feb 29 so plain four-year cycles work; undone in S_PICK
  assign days_adj = days_r + ((days_r >= 16'(MAR1_2100)) ? 16'd1 : 16'd0);

  assign cur_len = month_len(mon_r, leap_r);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (start) state_nxt = S_DAY;
      S_DAY:   if (div_rsp.done) state_nxt = S_HOUR;
      S_HOUR:  if (div_rsp.done) state_nxt = S_MIN;
      S_MIN:   if (div_rsp.done) state_nxt = S_YEAR;
      S_YEAR:  if (div_rsp.done) state_nxt = S_PICK;
      S_PICK:  state_nxt = S_MONTH;
      S_MONTH: if (!(mon_r < 4'd11 && {4'd0, cur_len} <= dy_r)) state_nxt = S_OUT;
      S_OUT:   state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // outputs and divider requests
  always_comb begin
    div_req   = '0;
    busy      = (state_r != S_IDLE);
    out_valid = (state_r == S_OUT);
    case (state_r)
      S_IDLE: begin
        div_req.start    = start;
        div_req.rem_init = {1'b0, local_t[31:16]};
        div_req.low_init = local_t[15:0];
        div_req.divisor  = DIV_REM_W'(SECS_PER_DAY);
        div_req.nbits    = DIV_CNT_W'(16);
      end
      S_DAY: begin
        div_req.start    = div_rsp.done;
        div_req.rem_init = {5'd0, div_rsp.rem[16:5]};
        div_req.low_init = {div_rsp.rem[4:0], 11'd0};
        div_req.divisor  = DIV_REM_W'(SECS_PER_HOUR);
        div_req.nbits    = DIV_CNT_W'(5);
      end
      S_HOUR: begin
        div_req.start    = div_rsp.done;
        div_req.rem_init = {11'd0, div_rsp.rem[11:6]};
        div_req.low_init = {div_rsp.rem[5:0], 10'd0};
        div_req.divisor  = DIV_REM_W'(SECS_PER_MIN);
        div_req.nbits    = DIV_CNT_W'(6);
      end
      S_MIN: begin
        div_req.start    = div_rsp.done;
        div_req.rem_init = {7'd0, days_adj[15:6]};
        div_req.low_init = {days_adj[5:0], 10'd0};
        div_req.divisor  = DIV_REM_W'(DAYS_PER_QUAD);
        div_req.nbits    = DIV_CNT_W'(6);
      end
      default: ;
    endcase
  end

  // datapath
  always_comb begin
    days_nxt = days_r;
    wd_nxt   = wd_r;
    hour_nxt = hour_r;
    min_nxt  = min_r;
    sec_nxt  = sec_r;
    year_nxt = year_r;
    dy_nxt   = dy_r;
    mon_nxt  = mon_r;
    leap_nxt = leap_r;
    wd_dbl   = {wd_r, div_rsp.qbit};
    case (state_r)
      S_IDLE: begin
        wd_nxt = 3'd0;
      end
      S_DAY: begin
        // day count mod 7, folded in as quotient bits arrive
        if (div_rsp.step) wd_nxt = (wd_dbl >= 4'd7) ? 3'(wd_dbl - 4'd7) : wd_dbl[2:0];
        if (div_rsp.done) days_nxt = div_rsp.quo;
      end
      S_HOUR: begin
        if (div_rsp.done) hour_nxt = div_rsp.quo[4:0];
      end
      S_MIN: begin
        if (div_rsp.done) begin
          min_nxt = div_rsp.quo[5:0];
          sec_nxt = div_rsp.rem[5:0];
        end
      end
      S_YEAR: begin
        // quad starts at 1970: common, common, leap, common
        if (div_rsp.done) begin
          if (div_rsp.rem[10:0] < 11'd365) begin
            year_nxt = 8'(BASE_YEAR) + {div_rsp.quo[5:0], 2'd0};
            dy_nxt   = div_rsp.rem[8:0];
          end else if (div_rsp.rem[10:0] < 11'd730) begin
            year_nxt = 8'(BASE_YEAR) + {div_rsp.quo[5:0], 2'd1};
            dy_nxt   = 9'(div_rsp.rem[10:0] - 11'd365);
          end else if (div_rsp.rem[10:0] < 11'd1096) begin
            year_nxt = 8'(BASE_YEAR) + {div_rsp.quo[5:0], 2'd2};
            dy_nxt   = 9'(div_rsp.rem[10:0] - 11'd730);
          end else begin
            year_nxt = 8'(BASE_YEAR) + {div_rsp.quo[5:0], 2'd3};
            dy_nxt   = 9'(div_rsp.rem[10:0] - 11'd1096);
          end
        end
      end
      S_PICK: begin
        leap_nxt = (year_r[1:0] == 2'd0) && (year_r != 8'(SKIPPED_LEAP));
        if (year_r == 8'(SKIPPED_LEAP) && dy_r >= 9'd60) dy_nxt = dy_r - 9'd1;
        mon_nxt = 4'd0;
      end
      S_MONTH: begin
        if (mon_r < 4'd11 && {4'd0, cur_len} <= dy_r) begin
          dy_nxt  = dy_r - {4'd0, cur_len};
          mon_nxt = mon_r + 4'd1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      tz_r    <= 5'd9;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) tz_r <= cfg_tz_offset_hours;
    end
    days_r <= days_nxt;
    wd_r   <= wd_nxt;
    hour_r <= hour_nxt;
    min_r  <= min_nxt;
    sec_r  <= sec_nxt;
    year_r <= year_nxt;
    dy_r   <= dy_nxt;
    mon_r  <= mon_nxt;
    leap_r <= leap_nxt;
  end

  // 1970-01-01 was a Thursday
  assign wd_sum = {1'b0, wd_r} + 4'd4;

  assign out_year_since_1900  = year_r;
  assign out_month_index      = mon_r;
  assign out_day_of_month     = dy_r[4:0] + 5'd1;
  assign out_hour_of_day      = hour_r;
  assign out_minute_of_hour   = min_r;
  assign out_second_of_minute = sec_r;
  assign out_weekday          = (wd_sum >= 4'd7) ? 3'(wd_sum - 4'd7) : wd_sum[2:0];
  assign out_days_in_month    = cur_len;

`ifndef SYNTHESIS
  a_accept_goes_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (busy && state_r == S_DAY))
    else $error("accepted word did not start the day division");

  a_strobe_then_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> (!out_valid && !busy))
    else $error("result strobe longer than one cycle");

  a_done_in_div_phase: assert property (@(posedge clk) disable iff (!rst_n)
    div_rsp.done |-> (state_r == S_DAY || state_r == S_HOUR ||
                      state_r == S_MIN || state_r == S_YEAR))
    else $error("divider finished outside a division phase");

  a_day_in_month: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_month_index <= 4'd11 && out_day_of_month <= out_days_in_month))
    else $error("day beyond end of month");
`endif

endmodule

// ----- tb/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Epoch-second to local calendar date converter: directed boundary words,
// then random words under several time-zone offsets and sender idle patterns.
// A scoreboard predicts every date word from the offset in force when the
// word is taken and checks each out_valid strobe field by field.
// ----------------------------------------------------------------------------
module testbench;
  import esc_pkg::*;

  typedef struct packed {
    logic [7:0] year;
    logic [3:0] month;
    logic [4:0] mday;
    logic [4:0] hour;
    logic [5:0] minute;
    logic [5:0] second;
    logic [2:0] wday;
    logic [4:0] mlen;
  } cal_date_t;

  class date_scoreboard;
    cal_date_t pending_dates[$];
    int        errors;
    int        checked;

    function new();
      errors  = 0;
      checked = 0;
    endfunction

    function bit is_leap(int unsigned yr);
      return (yr % 4 == 0) && (yr != SKIPPED_LEAP);
    endfunction

    function int unsigned month_days(int unsigned m, bit leap);
      int unsigned tab[12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
      if (m == 1 && leap) return 29;
      return tab[m];
    endfunction

    // local date of an epoch count with the offset added, sum wraps at 2^32
    function cal_date_t calendar_of(logic [31:0] secs, logic [4:0] tz);
      cal_date_t   d;
      int          hrs;
      logic [31:0] shift;
      logic [31:0] t;
      int unsigned days;
      int unsigned sod;
      int unsigned yr;
      int unsigned mon;
      bit          leap;
      hrs   = int'($signed(tz));
      shift = 32'(hrs * int'(SECS_PER_HOUR));
      t     = secs + shift;
      days  = t / SECS_PER_DAY;
      sod   = t % SECS_PER_DAY;
      d.wday = 3'((days + 4) % 7);
      yr = BASE_YEAR;
      while (days >= (is_leap(yr) ? 366 : 365)) begin
        days -= is_leap(yr) ? 366 : 365;
        yr++;
      end
      leap = is_leap(yr);
      mon  = 0;
      while (mon < 11 && days >= month_days(mon, leap)) begin
        days -= month_days(mon, leap);
        mon++;
      end
      d.year   = 8'(yr);
      d.month  = 4'(mon);
      d.mday   = 5'(days + 1);
      d.hour   = 5'(sod / SECS_PER_HOUR);
      d.minute = 6'((sod % SECS_PER_HOUR) / SECS_PER_MIN);
      d.second = 6'(sod % SECS_PER_MIN);
      d.mlen   = 5'(month_days(mon, leap));
      return d;
    endfunction

    function int pending();
      return pending_dates.size();
    endfunction

    task report_mismatch(string what);
      errors++;
      if (errors <= 40) $display("MISMATCH: %s", what);
    endtask

    function void note_word(logic [31:0] secs, logic [4:0] tz);
      pending_dates.push_back(calendar_of(secs, tz));
    endfunction

    task check_word(cal_date_t got);
      cal_date_t exp;
      if (pending_dates.size() == 0) begin
        report_mismatch("date word with nothing outstanding");
        return;
      end
      exp = pending_dates.pop_front();
      if (got.year !== exp.year)
        report_mismatch($sformatf("word %0d year got %0d exp %0d", checked, got.year, exp.year));
      if (got.month !== exp.month)
        report_mismatch($sformatf("word %0d month got %0d exp %0d", checked, got.month,
                                  exp.month));
      if (got.mday !== exp.mday)
        report_mismatch($sformatf("word %0d mday got %0d exp %0d", checked, got.mday, exp.mday));
      if (got.hour !== exp.hour)
        report_mismatch($sformatf("word %0d hour got %0d exp %0d", checked, got.hour, exp.hour));
      if (got.minute !== exp.minute)
        report_mismatch($sformatf("word %0d minute got %0d exp %0d", checked, got.minute,
                                  exp.minute));
      if (got.second !== exp.second)
        report_mismatch($sformatf("word %0d second got %0d exp %0d", checked, got.second,
                                  exp.second));
      if (got.wday !== exp.wday)
        report_mismatch($sformatf("word %0d weekday got %0d exp %0d", checked, got.wday,
                                  exp.wday));
      if (got.mlen !== exp.mlen)
        report_mismatch($sformatf("word %0d month length got %0d exp %0d", checked, got.mlen,
                                  exp.mlen));
      checked++;
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [31:0] in_epoch_seconds = '0;
  logic        cfg_we = 1'b0;
  logic [4:0]  cfg_tz_offset_hours = 5'd9;
  logic        out_valid;
  logic [7:0]  out_year_since_1900;
  logic [3:0]  out_month_index;
  logic [4:0]  out_day_of_month;
  logic [4:0]  out_hour_of_day;
  logic [5:0]  out_minute_of_hour;
  logic [5:0]  out_second_of_minute;
  logic [2:0]  out_weekday;
  logic [4:0]  out_days_in_month;

  logic [4:0]     tz_mirror = 5'd9;
  date_scoreboard sb = new();
  int             settings_used = 1;

  localparam logic [31:0] JAN1_2100 = 32'd4102444800;
  localparam logic [31:0] MAR1_2100_SECS = 32'd4107542400;

  epoch_seconds_to_calendar_date_core i_dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .start                (start),
    .busy                 (busy),
    .in_epoch_seconds     (in_epoch_seconds),
    .cfg_we               (cfg_we),
    .cfg_tz_offset_hours  (cfg_tz_offset_hours),
    .out_valid            (out_valid),
    .out_year_since_1900  (out_year_since_1900),
    .out_month_index      (out_month_index),
    .out_day_of_month     (out_day_of_month),
    .out_hour_of_day      (out_hour_of_day),
    .out_minute_of_hour   (out_minute_of_hour),
    .out_second_of_minute (out_second_of_minute),
    .out_weekday          (out_weekday),
    .out_days_in_month    (out_days_in_month)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // check before note: a strobe on the accepting edge belongs to an older word
  always @(posedge clk) begin
    if (!rst_n) begin
      tz_mirror <= 5'd9;
    end else begin
      if (out_valid)
        sb.check_word('{out_year_since_1900, out_month_index, out_day_of_month,
                        out_hour_of_day, out_minute_of_hour, out_second_of_minute,
                        out_weekday, out_days_in_month});
      if (start && !busy) sb.note_word(in_epoch_seconds, tz_mirror);
      if (cfg_we) tz_mirror <= cfg_tz_offset_hours;
    end
  end

  // called in the step of a rising edge; returns in the step of the taking edge
  task automatic send_word(input logic [31:0] w, input int idle_pct);
    if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
      // hold start low while the block is busy and through a random idle gap after it
      start <= 1'b0;
      @(posedge clk);
      while (busy) @(posedge clk);
      repeat ($urandom_range(0, 7)) @(posedge clk);
    end
    start            <= 1'b1;
    in_epoch_seconds <= w;
    do @(posedge clk); while (busy);
  endtask

  task automatic wait_idle();
    @(posedge clk);
    while (sb.pending() > 0 || busy) @(posedge clk);
  endtask

  task automatic write_offset(input logic [4:0] tz);
    cfg_we              <= 1'b1;
    cfg_tz_offset_hours <= tz;
    @(posedge clk);
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  // mix of full-range words and words near edges of the calendar
  function automatic logic [31:0] pick_epoch();
    int unsigned kind;
    logic [31:0] day;
    kind = $urandom_range(0, 9);
    case (kind)
      0, 1, 2, 3: return $urandom();
      4: return $urandom_range(0, 200000);
      5: return 32'hFFFF_FFFF - $urandom_range(0, 200000);
      6: return MAR1_2100_SECS + $urandom_range(0, 8 * 86400) - 4 * 86400;
      7: return JAN1_2100 + $urandom_range(0, 4 * 86400) - 2 * 86400;
      default: begin
        // just around a random midnight
        day = $urandom_range(0, 49709);
        return day * 86400 + $urandom_range(0, 4) - 2;
      end
    endcase
  endfunction

  initial begin
    logic [31:0] directed[$];
    logic [4:0]  phase_tz[6];
    int          phase_idle[6];
    directed = '{32'd0, 32'd1, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                 32'hAAAA_AAAA, 32'h5555_5555, 32'd68169600, 32'd94694399,
                 32'd946684799, 32'd951782400, JAN1_2100 - 32'd32401,
                 MAR1_2100_SECS - 32'd86400, MAR1_2100_SECS - 32'd32401,
                 MAR1_2100_SECS - 32'd32400, 32'd4260211200, 32'd4265078400,
                 32'hFFFF_FFFF - 32'd32400};
    phase_tz   = '{5'h10, 5'h0F, 5'h14, 5'd14, 5'd0, 5'd0};
    phase_idle = '{0, 47, 0, 6, 47, 0};
    phase_tz[5] = 5'($urandom_range(0, 31));

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset offset (+9 h) first
    foreach (directed[k]) send_word(directed[k], 0);
    start <= 1'b0;

    for (int p = 0; p < 6; p++) begin
      wait_idle();
      write_offset(phase_tz[p]);
      // both wrap directions for this offset
      send_word(32'd0, 0);
      send_word(32'hFFFF_FFFF, 0);
      for (int n = 0; n < 75; n++) send_word(pick_epoch(), phase_idle[p]);
      start <= 1'b0;
    end

    begin
      int waited;
      waited = 0;
      while (sb.pending() > 0 && waited < 2000) begin
        @(posedge clk);
        waited++;
      end
    end
    repeat (64) @(posedge clk);
    while (sb.pending() > 0) begin
      void'(sb.pending_dates.pop_front());
      sb.report_mismatch("date word never arrived");
    end

    $display("Checked %0d date words under %0d offset settings, -16 and +15 hours included.",
             sb.checked, settings_used);
    $display("Sender idle phases: none, 47 and 6 in a hundred; %0d mismatches.", sb.errors);
    if (sb.errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #3_200_000;
    $display("Timeout with %0d date words outstanding", sb.pending());
    $display("Regression FAIL");
    $finish;
  end

endmodule
